FILE: rtl/ille_pkg.sv
package ille_pkg;

  // Word field widths
  localparam int KIND_W   = 3;
  localparam int POS_W    = 11;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 11;

  // Operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_GET      = 3'd0,
    KIND_ADD_HEAD = 3'd1,
    KIND_ADD_TAIL = 3'd2,
    KIND_ADD_POS  = 3'd3,
    KIND_DELETE   = 3'd4
  } kind_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // Read value reported for a get beyond the list end
  localparam logic signed [VAL_W-1:0] READ_MISS = '1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_POP,
    ST_INS,
    ST_WALK,
    ST_FETCH,
    ST_LINK,
    ST_UNLINK,
    ST_RELEASE,
    ST_VALRD,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/ille_if.sv
interface ille_in_if;
  logic                               valid;
  logic                               ready;
  logic        [ille_pkg::KIND_W-1:0] kind;
  logic        [ille_pkg::POS_W-1:0]  position;
  logic signed [ille_pkg::VAL_W-1:0]  value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

interface ille_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ille_pkg::VAL_W-1:0]    read_value;
  logic        [ille_pkg::STATUS_W-1:0] status;
  logic        [ille_pkg::LEN_W-1:0]    list_length;

  modport source (output valid, read_value, status, list_length, input ready);
  modport sink   (input valid, read_value, status, list_length, output ready);
endinterface

FILE: rtl/indexed_linked_list_engine.sv
// Bounded singly linked list of CAPACITY nodes. Each input word is one operation (get, add at
// head, add at tail, add at a position, delete at a position) and gives exactly one result word
// with the read value, a status (done, position out of range, store full) and the list length
// after the operation. Node values and next links live in two synchronous memories with
// registered reads; deleted nodes go onto a free list and are reused first. Positions are
// found by following links from the head, one node per cycle through the link memory read port.
// One operation is in flight at a time; the next word is accepted in the cycle after the result
// is parked in the output register. No clearing pass runs after reset.
module indexed_linked_list_engine #(
  parameter int CAPACITY = 1024
) (
  input logic        clk,
  input logic        rst_n,
  ille_in_if.sink    in_ch,
  ille_out_if.source out_ch
);
  import ille_pkg::*;

  localparam int PW   = $clog2(CAPACITY + 1);
  localparam int AW   = $clog2(CAPACITY);
  localparam int CMPW = (PW > POS_W) ? PW : POS_W;
  localparam logic [PW-1:0] NIL = PW'(CAPACITY);

  // Control registers
  state_t          state_r, state_nxt;
  logic [PW-1:0]   head_r, head_nxt;
  logic [PW-1:0]   count_r, count_nxt;
  logic [PW-1:0]   free_head_r, free_head_nxt;
  logic [PW-1:0]   next_unused_r, next_unused_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Payload registers
  logic [KIND_W-1:0]        kind_r, kind_nxt;
  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic signed [VAL_W-1:0]  val_r, val_nxt;
  logic [PW-1:0]            cur_r, cur_nxt;
  logic [PW-1:0]            node_r, node_nxt;
  logic [PW-1:0]            steps_r, steps_nxt;
  logic [PW-1:0]            tpos_r, tpos_nxt;
  logic signed [VAL_W-1:0]  res_val_r, res_val_nxt;
  status_t                  res_status_r, res_status_nxt;
  logic signed [VAL_W-1:0]  out_val_r, out_val_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic [LEN_W-1:0]         out_len_r, out_len_nxt;

  // Node store
  logic signed [VAL_W-1:0]  value_mem [CAPACITY];
  logic [PW-1:0]            link_mem  [CAPACITY];
  logic signed [VAL_W-1:0]  vl_rdata_r;
  logic [PW-1:0]            lk_rdata_r;
  logic [PW-1:0]            rd_addr;
  logic                     lk_we;
  logic [PW-1:0]            lk_waddr;
  logic [PW-1:0]            lk_wdata;
  logic                     vl_we;

  // Decode helpers
  logic            in_fire;
  logic            out_free;
  logic            is_get, is_add, is_del;
  logic [CMPW-1:0] pos_ext, cnt_ext;
  logic            get_oob, ins_oob;
  logic            free_avail, unused_avail;
  logic [PW-1:0]   tpos_sel;
  logic            ins_at_head;
  logic [PW-1:0]   ins_steps, del_steps;
  logic            walk_last;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign is_get       = (kind_r == KIND_GET);
  assign is_add       = kind_r inside {KIND_ADD_HEAD, KIND_ADD_TAIL, KIND_ADD_POS};
  assign is_del       = (kind_r == KIND_DELETE);
  assign pos_ext      = CMPW'(pos_r);
  assign cnt_ext      = CMPW'(count_r);
  assign get_oob      = (pos_ext >= cnt_ext);
  assign ins_oob      = (kind_r == KIND_ADD_POS) && (pos_ext > cnt_ext);
  assign free_avail   = (free_head_r != NIL);
  assign unused_avail = (next_unused_r != NIL);
  assign ins_at_head  = (tpos_r == '0) || (head_r == NIL);
  assign ins_steps    = tpos_r - 1'b1;
  assign del_steps    = PW'(pos_r) - 1'b1;
  assign walk_last    = (steps_r == PW'(1));

  // Pick the landing position of an insert
  always_comb begin
    case (kind_r)
      KIND_ADD_HEAD: tpos_sel = '0;
      KIND_ADD_TAIL: tpos_sel = count_r;
      default:       tpos_sel = PW'(pos_r);
    endcase
  end

  // Handshake outputs
  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_value  = out_val_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.list_length = out_len_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (is_get) begin
          if (get_oob)             state_nxt = ST_DONE;
          else if (pos_r == '0)    state_nxt = ST_VALRD;
          else                     state_nxt = ST_WALK;
        end else if (is_add) begin
          if (ins_oob)             state_nxt = ST_DONE;
          else if (free_avail)     state_nxt = ST_POP;
          else if (unused_avail)   state_nxt = ST_INS;
          else                     state_nxt = ST_DONE;
        end else if (is_del) begin
          if (get_oob)             state_nxt = ST_DONE;
          else if (pos_r == '0)    state_nxt = ST_UNLINK;
          else if (del_steps == '0) state_nxt = ST_FETCH;
          else                     state_nxt = ST_WALK;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_POP: state_nxt = ST_INS;
      ST_INS: begin
        if (ins_at_head)          state_nxt = ST_DONE;
        else if (ins_steps == '0) state_nxt = ST_FETCH;
        else                      state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (walk_last) state_nxt = is_get ? ST_VALRD : ST_FETCH;
      end
      ST_FETCH:   state_nxt = is_del ? ST_UNLINK : ST_LINK;
      ST_LINK:    state_nxt = ST_DONE;
      ST_UNLINK:  state_nxt = ST_RELEASE;
      ST_RELEASE: state_nxt = ST_DONE;
      ST_VALRD:   state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    head_nxt        = head_r;
    count_nxt       = count_r;
    free_head_nxt   = free_head_r;
    next_unused_nxt = next_unused_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    kind_nxt        = kind_r;
    pos_nxt         = pos_r;
    val_nxt         = val_r;
    cur_nxt         = cur_r;
    node_nxt        = node_r;
    steps_nxt       = steps_r;
    tpos_nxt        = tpos_r;
    res_val_nxt     = res_val_r;
    res_status_nxt  = res_status_r;
    out_val_nxt     = out_val_r;
    out_status_nxt  = out_status_r;
    out_len_nxt     = out_len_r;
    rd_addr         = cur_r;
    lk_we           = 1'b0;
    lk_waddr        = node_r;
    lk_wdata        = head_r;
    vl_we           = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        // latch the incoming word
        if (in_fire) begin
          kind_nxt = in_ch.kind;
          pos_nxt  = in_ch.position;
          val_nxt  = in_ch.value;
        end
      end
      ST_DECIDE: begin
        res_val_nxt    = '0;
        res_status_nxt = STATUS_DONE;
        cur_nxt        = head_r;
        rd_addr        = head_r;
        if (is_get) begin
          if (get_oob) begin
            res_val_nxt    = READ_MISS;
            res_status_nxt = STATUS_RANGE;
          end else begin
            steps_nxt = PW'(pos_r);
          end
        end else if (is_add) begin
          tpos_nxt = tpos_sel;
          if (ins_oob) begin
            res_status_nxt = STATUS_RANGE;
          end else if (free_avail) begin
            // fetch the free node's link to advance the free list
            node_nxt = free_head_r;
            rd_addr  = free_head_r;
          end else if (unused_avail) begin
            node_nxt        = next_unused_r;
            next_unused_nxt = next_unused_r + 1'b1;
          end else begin
            res_status_nxt = STATUS_FULL;
          end
        end else if (is_del) begin
          if (get_oob) begin
            res_status_nxt = STATUS_RANGE;
          end else begin
            node_nxt  = head_r;
            steps_nxt = del_steps;
          end
        end
      end
      ST_POP: begin
        free_head_nxt = lk_rdata_r;
      end
      ST_INS: begin
        // store the value, then link at head or start following links to the predecessor
        vl_we   = 1'b1;
        cur_nxt = head_r;
        rd_addr = head_r;
        if (ins_at_head) begin
          lk_we     = 1'b1;
          lk_waddr  = node_r;
          lk_wdata  = head_r;
          head_nxt  = node_r;
          count_nxt = count_r + 1'b1;
        end else begin
          steps_nxt = ins_steps;
        end
      end
      ST_WALK: begin
        // advance one node per cycle
        rd_addr   = lk_rdata_r;
        cur_nxt   = lk_rdata_r;
        steps_nxt = steps_r - 1'b1;
      end
      ST_FETCH: begin
        if (is_del) begin
          node_nxt = lk_rdata_r;
          rd_addr  = lk_rdata_r;
        end else begin
          lk_we    = 1'b1;
          lk_waddr = node_r;
          lk_wdata = lk_rdata_r;
        end
      end
      ST_LINK: begin
        lk_we     = 1'b1;
        lk_waddr  = cur_r;
        lk_wdata  = node_r;
        count_nxt = count_r + 1'b1;
      end
      ST_UNLINK: begin
        if (pos_r == '0) begin
          head_nxt = lk_rdata_r;
        end else begin
          lk_we    = 1'b1;
          lk_waddr = cur_r;
          lk_wdata = lk_rdata_r;
        end
      end
      ST_RELEASE: begin
        // push the victim onto the free list
        lk_we         = 1'b1;
        lk_waddr      = node_r;
        lk_wdata      = free_head_r;
        free_head_nxt = node_r;
        count_nxt     = count_r - 1'b1;
      end
      ST_VALRD: begin
        res_val_nxt = vl_rdata_r;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_val_nxt    = res_val_r;
          out_status_nxt = res_status_r;
          out_len_nxt    = LEN_W'(count_r);
        end
      end
      default: begin
      end
    endcase
  end

  // Node store: one write and one registered read per memory each cycle
  always_ff @(posedge clk) begin
    if (lk_we) link_mem[lk_waddr[AW-1:0]] <= lk_wdata;
    if (vl_we) value_mem[node_r[AW-1:0]] <= val_r;
    lk_rdata_r <= link_mem[rd_addr[AW-1:0]];
    vl_rdata_r <= value_mem[rd_addr[AW-1:0]];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      head_r        <= NIL;
      count_r       <= '0;
      free_head_r   <= NIL;
      next_unused_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      head_r        <= head_nxt;
      count_r       <= count_nxt;
      free_head_r   <= free_head_nxt;
      next_unused_r <= next_unused_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    cur_r        <= cur_nxt;
    node_r       <= node_nxt;
    steps_r      <= steps_nxt;
    tpos_r       <= tpos_nxt;
    res_val_r    <= res_val_nxt;
    res_status_r <= res_status_nxt;
    out_val_r    <= out_val_nxt;
    out_status_r <= out_status_nxt;
    out_len_r    <= out_len_nxt;
  end

`ifndef SYNTH
  // Length changes only in the states that link or release a node
  a_count_src: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |->
      ($past(state_r) == ST_INS || $past(state_r) == ST_LINK ||
       $past(state_r) == ST_RELEASE))
    else $error("list length changed outside a link or release step");

  // Releasing a node shortens the list by one
  a_release_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RELEASE) |=> (count_r == $past(count_r) - 1'b1))
    else $error("release did not shorten the list");

  // Live nodes never outnumber the nodes handed out
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= next_unused_r)
    else $error("list length exceeds allocated nodes");

  // An accepted word always starts the decode step
  a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_DECIDE))
    else $error("accepted word did not reach decode");
`endif

endmodule

FILE: test/tb_indexed_linked_list_engine.sv
`timescale 1ns / 100ps

module tb_indexed_linked_list_engine;
  import ille_pkg::*;

  localparam int CAPACITY         = 1024;
  localparam int NIL              = CAPACITY;
  localparam int POS_LIMIT        = (1 << POS_W) - 1;
  localparam int KIND_SPARE_FIRST = 5;
  localparam int KIND_SPARE_LAST  = 7;
  localparam int RANDOM_OPS       = 540;
  localparam int LARGE_RANDOM_OPS = 12;
  localparam int HOLD_AT_RESULT   = 60;
  localparam int HOLD_CYCLES      = 400;
  localparam int STALL_LIMIT      = 8000;

  typedef struct {
    logic [KIND_W-1:0]       kind;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
    bit                      after_drain;
  } list_op_t;

  typedef struct {
    logic signed [VAL_W-1:0] read_value;
    status_t                 status;
    logic [LEN_W-1:0]        list_length;
  } list_result_t;

  logic clk;
  logic rst_n = 1'b0;

  ille_in_if  in_if ();
  ille_out_if out_if ();

  indexed_linked_list_engine #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  // Operations waiting to be offered and results waiting to arrive
  list_op_t     pending_ops[$];
  list_result_t expected_results[$];
  int           plan_len     = 0;
  int           ops_total    = 0;
  int           ops_accepted = 0;
  int           results_seen = 0;
  int           mismatches   = 0;

  // Shadow list: node store, links, head, free list and never-used pointer
  logic signed [VAL_W-1:0] shadow_value[CAPACITY];
  int                      shadow_link[CAPACITY];
  int                      shadow_head  = NIL;
  int                      shadow_len   = 0;
  int                      shadow_free  = NIL;
  int                      shadow_fresh = 0;

  // Follow links from the head for a number of steps
  function automatic int node_at(int steps);
    int n;
    n = shadow_head;
    for (int i = 0; i < steps && n != NIL; i++) n = shadow_link[n];
    return n;
  endfunction

  // Apply one operation to the shadow list and return its result word
  function automatic list_result_t apply_list_op(logic [KIND_W-1:0] kind,
                                                 logic [POS_W-1:0] position,
                                                 logic signed [VAL_W-1:0] value);
    list_result_t res;
    int pos;
    int node;
    int prev;
    pos = position;
    res.read_value = '0;
    res.status     = STATUS_DONE;
    case (kind)
      KIND_GET: begin
        if (pos >= shadow_len) begin
          res.read_value = READ_MISS;
          res.status     = STATUS_RANGE;
        end else begin
          res.read_value = shadow_value[node_at(pos)];
        end
      end
      KIND_ADD_HEAD, KIND_ADD_TAIL, KIND_ADD_POS: begin
        if (kind == KIND_ADD_HEAD) pos = 0;
        else if (kind == KIND_ADD_TAIL) pos = shadow_len;
        // range test first, then the full test
        if (pos > shadow_len) begin
          res.status = STATUS_RANGE;
        end else if (shadow_free == NIL && shadow_fresh == CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          // reuse freed nodes before untouched ones
          if (shadow_free != NIL) begin
            node        = shadow_free;
            shadow_free = shadow_link[node];
          end else begin
            node = shadow_fresh;
            shadow_fresh++;
          end
          shadow_value[node] = value;
          if (pos == 0) begin
            shadow_link[node] = shadow_head;
            shadow_head       = node;
          end else begin
            prev              = node_at(pos - 1);
            shadow_link[node] = shadow_link[prev];
            shadow_link[prev] = node;
          end
          shadow_len++;
        end
      end
      KIND_DELETE: begin
        if (pos >= shadow_len) begin
          res.status = STATUS_RANGE;
        end else begin
          if (pos == 0) begin
            node        = shadow_head;
            shadow_head = shadow_link[node];
          end else begin
            prev              = node_at(pos - 1);
            node              = shadow_link[prev];
            shadow_link[prev] = shadow_link[node];
          end
          shadow_link[node] = shadow_free;
          shadow_free       = node;
          shadow_len--;
        end
      end
      default: ;
    endcase
    res.list_length = LEN_W'(shadow_len);
    return res;
  endfunction

  // Queue one operation and track the length it leaves behind
  task automatic queue_op(logic [KIND_W-1:0] kind, int position,
                          logic signed [VAL_W-1:0] value, bit after_drain = 1'b0);
    list_op_t op;
    op.kind        = kind;
    op.position    = POS_W'(position);
    op.value       = value;
    op.after_drain = after_drain;
    pending_ops.push_back(op);
    case (kind)
      KIND_ADD_HEAD, KIND_ADD_TAIL: if (plan_len < CAPACITY) plan_len++;
      KIND_ADD_POS: if (position <= plan_len && plan_len < CAPACITY) plan_len++;
      KIND_DELETE: if (position < plan_len) plan_len--;
      default: ;
    endcase
  endtask

  // Mostly valid positions, some just past the end, some anywhere in the field
  function automatic int pick_position(int span);
    int r;
    r = $urandom_range(99, 0);
    if (r < 10) return $urandom_range(POS_LIMIT, 0);
    if (span == 0) return $urandom_range(1, 0);
    if (r < 25) return span + $urandom_range(1, 0);
    if (r < 40) return span - 1;
    return $urandom_range(span - 1, 0);
  endfunction

  // Random operation; length kept short by steering toward deletes or adds
  task automatic queue_random_op();
    int r;
    int span;
    logic [KIND_W-1:0] kind;
    logic signed [VAL_W-1:0] value;
    r = $urandom_range(99, 0);
    if (plan_len > 40 && r < 45) begin
      kind = KIND_DELETE;
    end else if (plan_len < 3 && r < 50) begin
      kind = KIND_W'($urandom_range(KIND_ADD_POS, KIND_ADD_HEAD));
    end else begin
      r = $urandom_range(99, 0);
      if (r < 28) kind = KIND_GET;
      else if (r < 42) kind = KIND_ADD_HEAD;
      else if (r < 56) kind = KIND_ADD_TAIL;
      else if (r < 72) kind = KIND_ADD_POS;
      else if (r < 94) kind = KIND_DELETE;
      else kind = KIND_W'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
    end
    span = (kind == KIND_ADD_POS) ? plan_len + 1 : plan_len;
    if ($urandom_range(9, 0) == 0) begin
      case ($urandom_range(3, 0))
        0: value = 32'sh8000_0000;
        1: value = 32'sh7fff_ffff;
        2: value = -32'sd1;
        default: value = '0;
      endcase
    end else begin
      value = $urandom;
    end
    queue_op(kind, pick_position(span), value, $urandom_range(39, 0) == 0);
  endtask

  // Clock and known input levels from time zero
  initial begin
    clk          = 1'b0;
    in_if.valid  = 1'b0;
    in_if.kind   = '0;
    in_if.position = '0;
    in_if.value  = '0;
    out_if.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: offer queued words, hold while stalled, idle between words
  int send_wait  = 0;
  bit send_burst = 1'b0;

  always @(posedge clk) begin
    list_op_t op;
    if (!rst_n) begin
      in_if.valid    <= 1'b0;
      in_if.kind     <= '0;
      in_if.position <= '0;
      in_if.value    <= '0;
      send_wait = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_results.push_back(apply_list_op(in_if.kind, in_if.position, in_if.value));
        ops_accepted++;
        if ($urandom_range(31, 0) == 0) send_burst = !send_burst;
        send_wait = send_burst ? 0 : $urandom_range(14, 0);
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_if.valid <= 1'b0;
        end else if (pending_ops.size() != 0 &&
                     !(pending_ops[0].after_drain && expected_results.size() != 0)) begin
          op = pending_ops.pop_front();
          in_if.valid    <= 1'b1;
          in_if.kind     <= op.kind;
          in_if.position <= op.position;
          in_if.value    <= op.value;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result word against the oldest expectation
  int  recv_wait  = 0;
  int  hold_left  = 0;
  bit  recv_burst = 1'b0;

  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word: read_value %0d status %0d list_length %0d",
                 out_if.read_value, out_if.status, out_if.list_length);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_if.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, out_if.read_value);
            mismatches++;
          end
          if (out_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_if.status);
            mismatches++;
          end
          if (out_if.list_length !== want.list_length) begin
            $error("list_length: expected %0d, got %0d", want.list_length,
                   out_if.list_length);
            mismatches++;
          end
        end
        results_seen++;
        // one long hold-off so the engine backs up into its input
        if (results_seen == HOLD_AT_RESULT) hold_left = HOLD_CYCLES;
        if ($urandom_range(31, 0) == 0) recv_burst = !recv_burst;
        recv_wait = recv_burst ? 0 : $urandom_range(14, 0);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL indexed_linked_list_engine");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    // empty list: every position is out of range
    queue_op(KIND_GET, 0, -32'sd1);
    queue_op(KIND_DELETE, 0, '0);
    queue_op(KIND_ADD_POS, 1, 32'sh1111_1111);
    // build five nodes: head, tail, append at length, insert in the middle
    queue_op(KIND_ADD_POS, 0, 32'sh8000_0000);
    queue_op(KIND_ADD_HEAD, 0, 32'sh7fff_ffff);
    queue_op(KIND_ADD_TAIL, 0, -32'sd1);
    queue_op(KIND_ADD_POS, 3, '0);
    queue_op(KIND_ADD_POS, 2, 32'sh5a5a_a5a5);
    for (int p = 0; p <= 5; p++) queue_op(KIND_GET, p, '0);
    queue_op(KIND_GET, POS_LIMIT, '0);
    queue_op(KIND_ADD_POS, POS_LIMIT, 32'sh0bad_f00d);
    queue_op(KIND_DELETE, POS_LIMIT, '0);
    // drop tail, head and a middle node, then reuse a freed node
    queue_op(KIND_DELETE, 4, '0);
    queue_op(KIND_DELETE, 0, '0);
    queue_op(KIND_DELETE, 1, '0);
    for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++) begin
      queue_op(KIND_W'(k), POS_LIMIT, -32'sd1);
    end
    queue_op(KIND_ADD_HEAD, 0, 32'sh1234_5678);
    queue_op(KIND_GET, 1, '0);

    // random operations on short lists; the first waits for the engine to drain
    queue_op(KIND_GET, 0, '0, 1'b1);
    for (int i = 0; i < RANDOM_OPS; i++) queue_random_op();

    // fill the store, then exercise the full and near-full cases
    queue_op(KIND_ADD_HEAD, 0, $urandom, 1'b1);
    while (plan_len < CAPACITY) queue_op(KIND_ADD_HEAD, 0, $urandom);
    queue_op(KIND_ADD_HEAD, 0, 32'sh0000_0001);
    queue_op(KIND_ADD_TAIL, 0, 32'sh0000_0002);
    queue_op(KIND_ADD_POS, CAPACITY, 32'sh0000_0003);
    queue_op(KIND_ADD_POS, CAPACITY + 1, 32'sh0000_0004);
    queue_op(KIND_GET, CAPACITY - 1, '0);
    queue_op(KIND_GET, CAPACITY, '0);
    queue_op(KIND_DELETE, CAPACITY, '0);
    queue_op(KIND_DELETE, CAPACITY - 1, '0);
    queue_op(KIND_ADD_TAIL, 0, 32'sh7fff_fffe);
    queue_op(KIND_GET, CAPACITY - 1, '0);
    queue_op(KIND_DELETE, CAPACITY / 2, '0);
    queue_op(KIND_ADD_POS, CAPACITY / 2, 32'sh8000_0001);
    queue_op(KIND_GET, CAPACITY / 2, '0);
    queue_op(KIND_ADD_HEAD, 0, 32'sh0000_0005);
    queue_op(KIND_DELETE, 0, '0);
    queue_op(KIND_ADD_POS, 0, -32'sd2);
    queue_op(KIND_GET, 0, '0);
    for (int i = 0; i < LARGE_RANDOM_OPS; i++) queue_random_op();
    ops_total = pending_ops.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every word to be accepted and answered, then watch for strays
    while (ops_accepted < ops_total || expected_results.size() != 0) @(posedge clk);
    repeat (CAPACITY + 16) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS indexed_linked_list_engine");
    end else begin
      $display("FAIL indexed_linked_list_engine");
    end
    $finish;
  end

endmodule
